[sv/vtq_pkg.sv]
// ----------------------------------------------------------------------------
// Versioned timer queue package
// Request and response types, codes and fixed constants of the timer queue.
// ----------------------------------------------------------------------------
package vtq_pkg;

   localparam logic [1:0] MODE_SCHED  = 2'd0;
   localparam logic [1:0] MODE_CANCEL = 2'd1;
   localparam logic [1:0] MODE_TICK   = 2'd2;

   localparam logic [1:0] KIND_SCHED  = 2'd0;
   localparam logic [1:0] KIND_CANCEL = 2'd1;
   localparam logic [1:0] KIND_EXPIRE = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOTPEND = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_STOP    = 2'd3;

   localparam int MAX_RESULTS = 64;
   localparam int VER_STEP    = 2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [47:0] deadline;
      logic [5:0]  slot_in;
      logic [31:0] version_in;
      logic [47:0] now;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  slot_out;
      logic [31:0] version_out;
      logic [1:0]  status;
      logic        earlier;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } cell_ctl_type;

endpackage

[sv/vtq_cell.sv]
// ----------------------------------------------------------------------------
// Versioned timer queue cell
// One entry of the sorted timer row: shifts right on insert, left on pop.
// ----------------------------------------------------------------------------
module vtq_cell
   import vtq_pkg::*;
#(
   parameter int TIME_BITS = 48,
   parameter int SW        = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctl_type         ctl,
   input  logic [TIME_BITS-1:0] new_dl,
   input  logic [SW-1:0]        new_slot,
   input  logic                 left_lt,
   input  logic                 left_valid,
   input  logic [TIME_BITS-1:0] left_dl,
   input  logic [SW-1:0]        left_slot,
   input  logic                 right_valid,
   input  logic [TIME_BITS-1:0] right_dl,
   input  logic [SW-1:0]        right_slot,
   output logic                 valid,
   output logic [TIME_BITS-1:0] dl,
   output logic [SW-1:0]        slot,
   output logic                 lt
);

   logic                 valid_ff, valid_in;
   logic [TIME_BITS-1:0] dl_ff, dl_in;
   logic [SW-1:0]        slot_ff, slot_in;

   assign lt    = !valid_ff || ({new_dl, new_slot} < {dl_ff, slot_ff});
   assign valid = valid_ff;
   assign dl    = dl_ff;
   assign slot  = slot_ff;

   always_comb begin
      valid_in = valid_ff;
      dl_in    = dl_ff;
      slot_in  = slot_ff;
      priority if (ctl.pop) begin
         valid_in = right_valid;
         dl_in    = right_dl;
         slot_in  = right_slot;
      end else if (ctl.insert && left_lt) begin
         valid_in = left_valid;
         dl_in    = left_dl;
         slot_in  = left_slot;
      end else if (ctl.insert && lt) begin
         valid_in = 1'b1;
         dl_in    = new_dl;
         slot_in  = new_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      dl_ff   <= dl_in;
      slot_ff <= slot_in;
   end

endmodule

[sv/versioned_timer_queue.sv]
// ----------------------------------------------------------------------------
// Versioned timer queue
// Timer engine with slot handles, versions, cancel and ordered expiry.
// ----------------------------------------------------------------------------
// Channel    Ports                               Handshake
// request    start, busy, req_data               taken when start and !busy
// response   rsp_strobe, rsp_data                one-cycle strobe, no stall
// config     psel, penable, pwrite, paddr, ...   APB write, pready always high
//
// Cancel reads the version store, then checks and replies. Schedule walks the
// busy bits up from slot 0 to the lowest free slot, then inserts the timer.
// A tick pops expired timers and cancelled heads. The version store has one
// write and one read port, and the sorted cell row shifts on insert or pop.
// Reset clears the row, the slot bits and the version valid bits at once.
// ----------------------------------------------------------------------------
module versioned_timer_queue
   import vtq_pkg::*;
#(
   parameter int SLOTS        = 64,
   parameter int TIME_BITS    = 48,
   parameter int VERSION_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int SW = $clog2(SLOTS);
   localparam int VB = VERSION_BITS;
   localparam int TB = TIME_BITS;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SCAN  = 4'd1;
   localparam logic [3:0] S_SCHED = 4'd2;
   localparam logic [3:0] S_CRD   = 4'd3;
   localparam logic [3:0] S_CCHK  = 4'd4;
   localparam logic [3:0] S_THEAD = 4'd5;
   localparam logic [3:0] S_TVER  = 4'd6;

   logic [3:0]       state_ff, state_in;
   req_type          req_ff, req_in;
   logic [SW-1:0]    idx_ff, idx_in;
   logic [SW-1:0]    cur_ff, cur_in;
   logic [6:0]       n_ff, n_in;
   logic             pend_ff, pend_in;
   logic [SW-1:0]    pslot_ff, pslot_in;
   logic [VB-1:0]    pver_ff, pver_in;
   logic [TB-1:0]    near_ff, near_in;
   logic             enable_ff;
   logic [SLOTS-1:0] busy_bits_ff, busy_bits_in;
   logic [SLOTS-1:0] canc_ff, canc_in;
   logic [SLOTS-1:0] vvalid_ff, vvalid_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_ff, rsp_in;

   logic [VB-1:0]    mem [SLOTS];
   logic [VB-1:0]    mem_q_ff;
   logic             vv_q_ff;
   logic [SW-1:0]    rd_addr;
   logic             we;
   logic [SW-1:0]    wa;
   logic [VB-1:0]    wd;

   cell_ctl_type     ctl;
   logic             c_valid [SLOTS];
   logic [TB-1:0]    c_dl    [SLOTS];
   logic [SW-1:0]    c_slot  [SLOTS];
   logic             c_lt    [SLOTS];

   logic [TB+47:0]   dl_ext, now_ext;
   logic [TB-1:0]    dl_t, now_t;
   logic [SW+5:0]    cidx_ext;
   logic [SW-1:0]    cidx;
   logic [SW+5:0]    sout_cur_ext, sout_p_ext;
   logic [VB-1:0]    ver_rd, ver_sched;
   logic [VB+31:0]   ver_rd_ext, ver_sched_ext, pver_ext;
   logic [VB-1:0]    ver_inc;
   logic             in_range, match;
   logic [SW-1:0]    hs;

   assign dl_ext       = {{TB{1'b0}}, req_ff.deadline};
   assign now_ext      = {{TB{1'b0}}, req_ff.now};
   assign dl_t         = dl_ext[TB-1:0];
   assign now_t        = now_ext[TB-1:0];
   assign cidx_ext     = {{SW{1'b0}}, req_ff.slot_in};
   assign cidx         = cidx_ext[SW-1:0];
   assign in_range     = 32'(req_ff.slot_in) < SLOTS;
   assign sout_cur_ext = {6'b0, cur_ff};
   assign sout_p_ext   = {6'b0, pslot_ff};
   assign ver_rd       = vv_q_ff ? mem_q_ff : VB'(VER_STEP);
   assign ver_sched    = (ver_rd == '0) ? VB'(VER_STEP) : ver_rd;
   assign ver_inc      = ver_rd + VB'(VER_STEP);
   assign ver_rd_ext   = {32'b0, ver_rd};
   assign ver_sched_ext = {32'b0, ver_sched};
   assign pver_ext     = {32'b0, pver_ff};
   assign match        = in_range && busy_bits_ff[cidx] && !canc_ff[cidx]
                         && (ver_rd_ext[31:0] == req_ff.version_in);
   assign hs           = c_slot[0];

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;
   assign pready     = 1'b1;
   assign prdata     = {31'b0, enable_ff};

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      logic          l_lt, l_valid, r_valid;
      logic [TB-1:0] l_dl, r_dl;
      logic [SW-1:0] l_slot, r_slot;
      if (i == 0) begin : g_first
         assign l_lt    = 1'b0;
         assign l_valid = 1'b0;
         assign l_dl    = '0;
         assign l_slot  = '0;
      end else begin : g_mid
         assign l_lt    = c_lt[i-1];
         assign l_valid = c_valid[i-1];
         assign l_dl    = c_dl[i-1];
         assign l_slot  = c_slot[i-1];
      end
      if (i == SLOTS - 1) begin : g_last
         assign r_valid = 1'b0;
         assign r_dl    = '0;
         assign r_slot  = '0;
      end else begin : g_inner
         assign r_valid = c_valid[i+1];
         assign r_dl    = c_dl[i+1];
         assign r_slot  = c_slot[i+1];
      end
      vtq_cell #(.TIME_BITS(TB), .SW(SW)) u_cell (
         .clock(clock), .reset(reset), .ctl(ctl),
         .new_dl(dl_t), .new_slot(cur_ff),
         .left_lt(l_lt), .left_valid(l_valid), .left_dl(l_dl), .left_slot(l_slot),
         .right_valid(r_valid), .right_dl(r_dl), .right_slot(r_slot),
         .valid(c_valid[i]), .dl(c_dl[i]), .slot(c_slot[i]), .lt(c_lt[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      cur_in        = cur_ff;
      n_in          = n_ff;
      pend_in       = pend_ff;
      pslot_in      = pslot_ff;
      pver_in       = pver_ff;
      near_in       = near_ff;
      busy_bits_in  = busy_bits_ff;
      canc_in       = canc_ff;
      vvalid_in     = vvalid_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      rd_addr       = cur_ff;
      we            = 1'b0;
      wa            = cur_ff;
      wd            = ver_inc;
      ctl           = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               idx_in = '0;
               n_in   = '0;
               pend_in = 1'b0;
               unique case (req_data.mode)
                  MODE_SCHED: begin
                     if (enable_ff) begin
                        state_in = S_SCAN;
                     end else begin
                        rsp_strobe_in  = 1'b1;
                        rsp_in.kind    = KIND_SCHED;
                        rsp_in.status  = ST_STOP;
                        rsp_in.last    = 1'b1;
                     end
                  end
                  MODE_CANCEL: state_in = S_CRD;
                  MODE_TICK:   state_in = S_THEAD;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN: begin
            rd_addr = idx_ff;
            priority if (!busy_bits_ff[idx_ff]) begin
               cur_in   = idx_ff;
               state_in = S_SCHED;
            end else if (idx_ff == SW'(SLOTS - 1)) begin
               rsp_strobe_in = 1'b1;
               rsp_in.kind   = KIND_SCHED;
               rsp_in.status = ST_FULL;
               rsp_in.last   = 1'b1;
               state_in      = S_IDLE;
            end else begin
               idx_in = idx_ff + SW'(1);
            end
         end
         S_SCHED: begin
            we                   = 1'b1;
            wd                   = ver_sched;
            vvalid_in[cur_ff]    = 1'b1;
            busy_bits_in[cur_ff] = 1'b1;
            canc_in[cur_ff]      = 1'b0;
            ctl.insert           = 1'b1;
            if (dl_t < near_ff) begin
               near_in = dl_t;
            end
            rsp_strobe_in      = 1'b1;
            rsp_in.kind        = KIND_SCHED;
            rsp_in.slot_out    = sout_cur_ext[5:0];
            rsp_in.version_out = ver_sched_ext[31:0];
            rsp_in.status      = ST_OK;
            rsp_in.earlier     = dl_t < near_ff;
            rsp_in.last        = 1'b1;
            state_in           = S_IDLE;
         end
         S_CRD: begin
            rd_addr  = cidx;
            state_in = S_CCHK;
         end
         S_CCHK: begin
            wa = cidx;
            if (match) begin
               we              = 1'b1;
               vvalid_in[cidx] = 1'b1;
               canc_in[cidx]   = 1'b1;
            end
            rsp_strobe_in      = 1'b1;
            rsp_in.kind        = KIND_CANCEL;
            rsp_in.slot_out    = req_ff.slot_in;
            rsp_in.version_out = req_ff.version_in;
            rsp_in.status      = match ? ST_OK : ST_NOTPEND;
            rsp_in.last        = 1'b1;
            state_in           = S_IDLE;
         end
         S_THEAD: begin
            rd_addr = hs;
            priority if (!c_valid[0] || (!canc_ff[hs] &&
                         (c_dl[0] > now_t || n_ff == 7'(MAX_RESULTS)))) begin
               near_in = c_valid[0] ? c_dl[0] : '1;
               if (pend_ff) begin
                  rsp_strobe_in      = 1'b1;
                  rsp_in.kind        = KIND_EXPIRE;
                  rsp_in.slot_out    = sout_p_ext[5:0];
                  rsp_in.version_out = pver_ext[31:0];
                  rsp_in.status      = ST_OK;
                  rsp_in.last        = 1'b1;
               end
               pend_in  = 1'b0;
               state_in = S_IDLE;
            end else if (canc_ff[hs]) begin
               ctl.pop          = 1'b1;
               busy_bits_in[hs] = 1'b0;
               canc_in[hs]      = 1'b0;
            end else begin
               ctl.pop          = 1'b1;
               busy_bits_in[hs] = 1'b0;
               cur_in           = hs;
               state_in         = S_TVER;
            end
         end
         S_TVER: begin
            we                = 1'b1;
            wd                = ver_inc;
            vvalid_in[cur_ff] = 1'b1;
            if (pend_ff) begin
               rsp_strobe_in      = 1'b1;
               rsp_in.kind        = KIND_EXPIRE;
               rsp_in.slot_out    = sout_p_ext[5:0];
               rsp_in.version_out = pver_ext[31:0];
               rsp_in.status      = ST_OK;
               rsp_in.last        = 1'b0;
            end
            pend_in  = 1'b1;
            pslot_in = cur_ff;
            pver_in  = ver_rd;
            n_in     = n_ff + 7'd1;
            state_in = S_THEAD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      mem_q_ff <= mem[rd_addr];
      vv_q_ff  <= vvalid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_ff       <= 1'b0;
         n_ff          <= '0;
         near_ff       <= '1;
         enable_ff     <= 1'b0;
         busy_bits_ff  <= '0;
         canc_ff       <= '0;
         vvalid_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         n_ff          <= n_in;
         near_ff       <= near_in;
         busy_bits_ff  <= busy_bits_in;
         canc_ff       <= canc_in;
         vvalid_ff     <= vvalid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            enable_ff <= pwdata[0];
         end
      end
      req_ff   <= req_in;
      idx_ff   <= idx_in;
      cur_ff   <= cur_in;
      pslot_ff <= pslot_in;
      pver_ff  <= pver_in;
      rsp_ff   <= rsp_in;
   end

endmodule

[sv/vtq_checker.sv]
// ----------------------------------------------------------------------------
// Versioned timer queue checker
// Port-level assertions on the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module vtq_checker
   import vtq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   a_reply_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.kind != KIND_EXPIRE |-> rsp_data.last)
      else $error("schedule or cancel reply without last");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.kind == KIND_SCHED && rsp_data.status != ST_OK
      |-> rsp_data.slot_out == '0 && rsp_data.version_out == '0
          && !rsp_data.earlier)
      else $error("refused schedule carries a handle");

   a_cancel_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.mode == MODE_CANCEL |=> busy)
      else $error("cancel request did not occupy the block");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !busy && !rsp_strobe)
      else $error("activity right after reset");

endmodule

bind versioned_timer_queue vtq_checker u_vtq_checker (.*);
